/* rtl/core/aoi_pkg.sv */
package aoi_pkg;

	localparam int CORDIC_ITERS = 16;
	localparam int CORDIC_STEPS = (CORDIC_ITERS > 32) ? 32 : CORDIC_ITERS;

	localparam logic signed [31:0] PI_Q        = 32'sd843314857;
	localparam logic signed [31:0] HALF_PI_Q   = 32'sd421657428;
	localparam logic signed [33:0] TWO_PI_Q    = 34'sd1686629714;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [15:0] STEER_LIMIT = 16'sd22938;
	localparam logic [15:0]        WB_MIN      = 16'd64;
	localparam logic [15:0]        WB_RESET    = 16'd256;
	localparam logic [15:0]        T_RESET     = 16'd655;

	localparam logic [7:0] REG_WHEELBASE   = 8'd0;
	localparam logic [7:0] REG_STEP_PERIOD = 8'd1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CH, ST_MX, ST_MY, ST_AY, ST_CS, ST_DT,
		ST_MT, ST_MW, ST_DH, ST_MH, ST_FIN
	} aoi_state_t;

	// arctan(2^-i), Q3.28
	function automatic logic signed [31:0] atan_q28(input logic [4:0] i);
		logic signed [31:0] r;
		case (i)
			5'd0:  r = 32'sd210828714;
			5'd1:  r = 32'sd124459457;
			5'd2:  r = 32'sd65760959;
			5'd3:  r = 32'sd33381290;
			5'd4:  r = 32'sd16755422;
			5'd5:  r = 32'sd8385879;
			5'd6:  r = 32'sd4193963;
			5'd7:  r = 32'sd2097109;
			5'd8:  r = 32'sd1048571;
			5'd9:  r = 32'sd524287;
			5'd10: r = 32'sd262144;
			5'd11: r = 32'sd131072;
			5'd12: r = 32'sd65536;
			5'd13: r = 32'sd32768;
			5'd14: r = 32'sd16384;
			5'd15: r = 32'sd8192;
			5'd16: r = 32'sd4096;
			5'd17: r = 32'sd2048;
			5'd18: r = 32'sd1024;
			5'd19: r = 32'sd512;
			5'd20: r = 32'sd256;
			5'd21: r = 32'sd128;
			5'd22: r = 32'sd64;
			5'd23: r = 32'sd32;
			5'd24: r = 32'sd16;
			5'd25: r = 32'sd8;
			5'd26: r = 32'sd4;
			5'd27: r = 32'sd2;
			5'd28: r = 32'sd1;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/aoi_in_if.sv */
interface aoi_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] speed;
	logic signed [15:0] steer_angle;
	modport source (output valid, speed, steer_angle, input ready);
	modport sink (input valid, speed, steer_angle, output ready);
endinterface

/* rtl/core/aoi_out_if.sv */
interface aoi_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [30:0] heading;
	modport source (output valid, pos_x, pos_y, heading, input ready);
	modport sink (input valid, pos_x, pos_y, heading, output ready);
endinterface

/* rtl/core/aoi_cfg_if.sv */
interface aoi_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/aoi_cordic.sv */
module aoi_cordic import aoi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] angle,
	output logic               done,
	output logic signed [33:0] cos_o,
	output logic signed [33:0] sin_o
);
	logic signed [33:0] x_q, y_q;
	logic signed [31:0] z_q;
	logic [5:0]         cnt_q;
	logic               busy_q, done_q, neg_q;
	logic [4:0]         idx;

	assign idx = cnt_q[4:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CORDIC_GAIN;
			y_q <= '0;
			// fold outer half-planes by pi, negate at the end
			if (angle > HALF_PI_Q) begin
				z_q   <= angle - PI_Q;
				neg_q <= 1'b1;
			end else if (angle < -HALF_PI_Q) begin
				z_q   <= angle + PI_Q;
				neg_q <= 1'b1;
			end else begin
				z_q   <= angle;
				neg_q <= 1'b0;
			end
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - (y_q >>> idx);
				y_q <= y_q + (x_q >>> idx);
				z_q <= z_q - atan_q28(idx);
			end else begin
				x_q <= x_q + (y_q >>> idx);
				y_q <= y_q - (x_q >>> idx);
				z_q <= z_q + atan_q28(idx);
			end
		end
	end

	assign done  = done_q;
	assign cos_o = neg_q ? -x_q : x_q;
	assign sin_o = neg_q ? -y_q : y_q;

endmodule

/* rtl/core/aoi_div.sv */
module aoi_div import aoi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [63:0] quot
);
	logic [63:0] q_q;
	logic [31:0] r_q, d_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [32:0] trial;
	logic        fits;

	// restoring, one quotient bit per cycle
	assign trial = {r_q, q_q[63]};
	assign fits  = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			r_q <= fits ? 32'(trial - {1'b0, d_q}) : trial[31:0];
			q_q <= {q_q[62:0], fits};
		end
	end

	assign done = done_q;
	assign quot = q_q;

endmodule

/* rtl/core/ackermann_odometry_integrator.sv */
// From tick transfer to pose valid: two CORDIC passes, two divides and a
//   10-step heading reduction.
// A new tick is taken only when idle, so one tick is processed at a time, and a
//   pose not yet taken holds the final step.
// Reset (arst_n low): pose and heading clear to zero, wheelbase 1.0 m,
//   period 655/65536 s, no result pending.
module ackermann_odometry_integrator import aoi_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	aoi_in_if.sink   ticks,
	aoi_out_if.source pose,
	aoi_cfg_if.sink  cfg
);
	aoi_state_t state_q, state_d;

	// configuration
	logic [15:0] wheelbase_q, step_period_q, wb_eff;

	// pose state
	logic signed [31:0] x_acc_q, y_acc_q, heading_acc_q;

	// per-tick working registers
	logic signed [31:0] vt_q;      // v*T, Q8.24
	logic signed [15:0] st_q;      // clamped steer, Q2.14
	logic signed [31:0] ch_q, sh_q, tn_q;
	logic               neg_q;     // sign carried into a divide or the heading reduction
	logic signed [63:0] prod_q;
	logic [40:0]        hmag_q;    // |unwrapped heading sum|, reduced in place
	logic [3:0]         red_k_q;   // reduction step: subtract 2*pi*2^k

	// output register
	logic               out_valid_q;
	logic signed [31:0] out_x_q, out_y_q;
	logic signed [30:0] out_h_q;

	// shared units
	logic               cord_start, cord_done;
	logic signed [31:0] cord_angle;
	logic signed [33:0] cord_cos, cord_sin;
	logic               div_start, div_done;
	logic [63:0]        div_dividend, div_quot;
	logic [31:0]        div_divisor;
	logic signed [31:0] mul_a, mul_b;

	logic               in_xfer, out_xfer, load_out;
	logic signed [32:0] vt_full;
	logic signed [15:0] st_clamp;
	logic signed [63:0] inc_pos, sum_pos, sat_pos;
	logic signed [33:0] cs_clamp;
	logic [63:0]        abs_prod;
	logic signed [63:0] dth;
	logic signed [63:0] h_sum;
	logic [40:0]        red_sub, red_next;
	logic               red_fits;
	logic signed [33:0] r_signed, r_wrap;

	assign in_xfer  = ticks.valid && ticks.ready;
	assign out_xfer = pose.valid && pose.ready;
	assign cfg.ready = 1'b1;

	assign wb_eff   = (wheelbase_q < WB_MIN) ? WB_MIN : wheelbase_q;
	assign vt_full  = ticks.speed * $signed({1'b0, step_period_q});
	assign st_clamp = (ticks.steer_angle > STEER_LIMIT) ? STEER_LIMIT :
		(ticks.steer_angle < -STEER_LIMIT) ? -STEER_LIMIT : ticks.steer_angle;

	// position increment: round half up from Q10.54 to Q16.16, then saturate
	assign inc_pos = (prod_q + 64'sh20_0000_0000) >>> 38;
	assign sum_pos = ((state_q == ST_MY) ? 64'(x_acc_q) : 64'(y_acc_q)) + inc_pos;
	assign sat_pos = (sum_pos > 64'sh7FFF_FFFF) ? 64'sh7FFF_FFFF :
		(sum_pos < -64'sh8000_0000) ? -64'sh8000_0000 : sum_pos;

	assign cs_clamp = (cord_cos < 34'sd1) ? 34'sd1 : cord_cos;
	assign abs_prod = prod_q[63] ? 64'(-prod_q) : 64'(prod_q);
	assign dth      = neg_q ? -$signed(div_quot) : $signed(div_quot);

	// |heading + step| stays below 2*pi*2^10, so ten conditional
	// subtracts (k = 9 down to 0) leave the remainder by 2*pi
	assign h_sum    = 64'(heading_acc_q) + dth;
	assign red_sub  = 41'(TWO_PI_Q) << red_k_q;
	assign red_fits = hmag_q >= red_sub;
	assign red_next = red_fits ? hmag_q - red_sub : hmag_q;

	// truncating remainder, then into [-pi, pi)
	assign r_signed = neg_q ? -$signed({3'b0, red_next[30:0]}) :
		$signed({3'b0, red_next[30:0]});
	assign r_wrap   = (r_signed >= 34'(PI_Q)) ? r_signed - TWO_PI_Q :
		(r_signed < -34'(PI_Q)) ? r_signed + TWO_PI_Q : r_signed;

	assign load_out = (state_q == ST_FIN) && (!out_valid_q || pose.ready);

	aoi_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cord_start),
		.angle  (cord_angle),
		.done   (cord_done),
		.cos_o  (cord_cos),
		.sin_o  (cord_sin)
	);

	aoi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state and unit controls
	always_comb begin
		state_d      = state_q;
		ticks.ready  = 1'b0;
		cord_start   = 1'b0;
		cord_angle   = heading_acc_q;
		div_start    = 1'b0;
		div_dividend = abs_prod;
		div_divisor  = cs_clamp[31:0];
		mul_a        = vt_q;
		mul_b        = ch_q;
		case (state_q)
			ST_IDLE: begin
				ticks.ready = 1'b1;
				if (ticks.valid) begin
					cord_start = 1'b1;
					state_d    = ST_CH;
				end
			end
			ST_CH: if (cord_done) state_d = ST_MX;
			ST_MX: state_d = ST_MY;
			ST_MY: begin
				mul_b   = sh_q;
				state_d = ST_AY;
			end
			ST_AY: begin
				cord_start = 1'b1;
				cord_angle = {{2{st_q[15]}}, st_q, 14'b0};
				state_d    = ST_CS;
			end
			ST_CS: begin
				if (cord_done) begin
					div_start    = 1'b1;
					div_dividend = 64'({(cord_sin[33] ? 34'(-cord_sin) : cord_sin), 28'b0});
					state_d      = ST_DT;
				end
			end
			ST_DT: if (div_done) state_d = ST_MT;
			ST_MT: begin
				mul_b   = tn_q;
				state_d = ST_MW;
			end
			ST_MW: begin
				div_start    = 1'b1;
				div_dividend = abs_prod + {33'b0, wb_eff, 15'b0};
				div_divisor  = {wb_eff, 16'b0};
				state_d      = ST_DH;
			end
			ST_DH: begin
				if (div_done) state_d = ST_MH;
			end
			ST_MH: begin
				if (red_k_q == 4'd0) state_d = ST_FIN;
			end
			ST_FIN: if (load_out) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// shared multiplier, registered
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			vt_q <= vt_full[31:0];
			st_q <= st_clamp;
		end
		if (state_q == ST_CH && cord_done) begin
			ch_q <= cord_cos[31:0];
			sh_q <= cord_sin[31:0];
		end
		if (state_q == ST_CS && cord_done) begin
			neg_q <= cord_sin[33];
		end
		if (state_q == ST_DT && div_done) begin
			tn_q <= neg_q ? -$signed(div_quot[31:0]) : $signed(div_quot[31:0]);
		end
		if (state_q == ST_MW) begin
			neg_q <= prod_q[63];
		end
		if (state_q == ST_DH && div_done) begin
			hmag_q  <= h_sum[63] ? 41'(-h_sum) : 41'(h_sum);
			neg_q   <= h_sum[63];
			red_k_q <= 4'd9;
		end
		if (state_q == ST_MH) begin
			hmag_q <= red_next;
			if (red_k_q != 4'd0) red_k_q <= red_k_q - 4'd1;
		end
		if (load_out) begin
			out_x_q <= x_acc_q;
			out_y_q <= y_acc_q;
			out_h_q <= heading_acc_q[30:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheelbase_q   <= WB_RESET;
			step_period_q <= T_RESET;
			x_acc_q       <= '0;
			y_acc_q       <= '0;
			heading_acc_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					REG_WHEELBASE:   wheelbase_q   <= cfg.data;
					REG_STEP_PERIOD: step_period_q <= cfg.data;
					default: ;
				endcase
			end
			if (state_q == ST_MY) x_acc_q <= sat_pos[31:0];
			if (state_q == ST_AY) y_acc_q <= sat_pos[31:0];
			if (state_q == ST_MH && red_k_q == 4'd0) heading_acc_q <= r_wrap[31:0];
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign pose.valid   = out_valid_q;
	assign pose.pos_x   = out_x_q;
	assign pose.pos_y   = out_y_q;
	assign pose.heading = out_h_q;

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !ticks.ready)
		else $error("tick taken while a tick is in flight");

	a_heading_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		(heading_acc_q >= -PI_Q) && (heading_acc_q < PI_Q))
		else $error("heading left [-pi, pi)");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result raised outside the final step");

	a_no_overload: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || pose.ready))
		else $error("result register overwritten");

endmodule
